// ----- hdl/kcd_pkg.sv -----
// Package for the key command decoder: key byte constants, the fixed letter code table
// and the decoder state type. It has no dependencies.
package kcd_pkg;

    localparam int KeyWidth  = 8;
    localparam int CodeWidth = 32;

    localparam logic [KeyWidth-1:0] KEY_NONE    = 8'h00;
    localparam logic [KeyWidth-1:0] KEY_NL      = 8'h0a;
    localparam logic [KeyWidth-1:0] KEY_ESC     = 8'h1b;
    localparam logic [KeyWidth-1:0] KEY_BRACKET = 8'h5b;
    localparam logic [KeyWidth-1:0] KEY_PLUS    = 8'h2b;
    localparam logic [KeyWidth-1:0] KEY_MINUS   = 8'h2d;
    localparam logic [KeyWidth-1:0] KEY_DIGIT_0 = 8'h30;
    localparam logic [KeyWidth-1:0] KEY_DIGIT_9 = 8'h39;
    localparam logic [KeyWidth-1:0] KEY_ARROW_A = 8'h41;
    localparam logic [KeyWidth-1:0] KEY_ARROW_D = 8'h44;
    localparam logic [KeyWidth-1:0] KEY_LOWER_C = 8'h63;
    localparam logic [KeyWidth-1:0] KEY_LOWER_Q = 8'h71;
    localparam logic [KeyWidth-1:0] KEY_LOWER_R = 8'h72;

    localparam logic [CodeWidth-1:0] CODE_NONE   = 32'h0;
    localparam logic [CodeWidth-1:0] CODE_QUIT   = 32'h0000_0071;
    localparam logic [CodeWidth-1:0] CODE_BASE   = 32'h001b_4b00;
    localparam logic [CodeWidth-1:0] ARROW_BASE  = 32'h001b_5b00;
    localparam logic [CodeWidth-1:0] ESC_NUMBER  = 32'h0000_001b;
    localparam logic [CodeWidth-1:0] BRACKET_NUM = 32'h0000_005b;

    typedef struct packed {
        logic [CodeWidth-1:0] command_number;
        logic [CodeWidth-1:0] value_number;
        logic [CodeWidth-1:0] escape_second;
        logic                 value_entry;
    } kcd_state_t;

    // Low byte of the fixed code of a letter key, zero when the key has none.
    function automatic logic [KeyWidth-1:0] letter_code(input logic [KeyWidth-1:0] key);
        logic [KeyWidth-1:0] low;
        unique case (key)
            8'h77:   low = 8'h41;
            8'h73:   low = 8'h42;
            8'h64:   low = 8'h43;
            8'h61:   low = 8'h44;
            8'h65:   low = 8'h45;
            8'h74:   low = 8'h46;
            8'h79:   low = 8'h47;
            8'h75:   low = 8'h48;
            8'h69:   low = 8'h49;
            8'h6f:   low = 8'h50;
            8'h70:   low = 8'h51;
            8'h6c:   low = 8'h52;
            8'h6e:   low = 8'h53;
            8'h6d:   low = 8'h54;
            8'h76:   low = 8'h55;
            8'h78:   low = 8'h56;
            8'h7a:   low = 8'h57;
            8'h67:   low = 8'h58;
            8'h62:   low = 8'h59;
            8'h66:   low = 8'h60;
            8'h68:   low = 8'h61;
            8'h6a:   low = 8'h62;
            8'h6b:   low = 8'h63;
            default: low = 8'h00;
        endcase
        return low;
    endfunction

endpackage

// ----- hdl/key_command_decoder_top.sv -----
// Key command decoder top level: input register, decoder state, decoder logic and
// result register with stream handshakes. Depends on kcd_pkg and kcd_decode.
// A key item accepted into the input register is decoded from there into the result register.
// Throughput: one item per cycle; the input register refills while the result register
// drains, so only a stalled m_tready holds the input side back.
// Reset clears the valid flags, the command and value numbers, the escape byte and the
// value-entry flag.
module key_command_decoder_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] key_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] code
    output logic        m_tuser    // [0] advance_handler
);
    import kcd_pkg::*;

    logic                 in_valid_reg;
    logic [KeyWidth-1:0]  key_reg;
    logic                 out_valid_reg;
    logic [CodeWidth-1:0] code_reg;
    logic                 adv_reg;
    kcd_state_t           state_reg;
    kcd_state_t           state_next;
    logic [CodeWidth-1:0] code_next;
    logic                 adv_next;
    logic                 advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    kcd_decode u_decode (
        .key             (key_reg),
        .state           (state_reg),
        .state_next      (state_next),
        .code            (code_next),
        .advance_handler (adv_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            key_reg <= s_tdata;
        if (advance)
        begin
            code_reg <= code_next;
            adv_reg  <= adv_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = code_reg;
    assign m_tuser  = adv_reg;

    a_adv_code_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == CODE_NONE)
        else $error("handler advance item carries a nonzero code");

    a_state_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("decoder state changed without an item moving to the result register");

    a_no_key_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
        advance && key_reg == KEY_NONE |=> $stable(state_reg) && m_tdata == CODE_NONE)
        else $error("empty key changed state or gave a code");

endmodule

// ----- hdl/kcd_decode.sv -----
// Combinational key decoder: from one key byte and the current state it forms the
// result code, the handler-advance flag and the next state. Depends on kcd_pkg.
module kcd_decode (
    input  logic [kcd_pkg::KeyWidth-1:0]  key,
    input  kcd_pkg::kcd_state_t           state,
    output kcd_pkg::kcd_state_t           state_next,
    output logic [kcd_pkg::CodeWidth-1:0] code,
    output logic                          advance_handler
);
    import kcd_pkg::*;

    logic [KeyWidth-1:0]  low;
    logic [3:0]           digit;
    logic [CodeWidth-1:0] selected;
    logic [CodeWidth-1:0] times_ten;
    logic [CodeWidth-1:0] stepped;

    assign low      = letter_code(key);
    assign digit    = 4'(key - KEY_DIGIT_0);
    assign selected = state.value_entry ? state.value_number : state.command_number;
    assign times_ten = {selected[CodeWidth-4:0], 3'b000} + {selected[CodeWidth-2:0], 1'b0}
                     + {{(CodeWidth-4){1'b0}}, digit};
    assign stepped  = (key == KEY_PLUS) ? state.escape_second + 32'd1
                                        : state.escape_second - 32'd1;

    always_comb
    begin
        state_next      = state;
        code            = CODE_NONE;
        advance_handler = 1'b0;
        priority if (key == KEY_NONE)
        begin
        end
        else if (low != 8'h00)
        begin
            state_next.command_number = '0;
            state_next.value_number   = '0;
            state_next.value_entry    = 1'b0;
            code = CODE_BASE | {{(CodeWidth-KeyWidth){1'b0}}, low};
        end
        else if (key == KEY_LOWER_Q)
        begin
            state_next.command_number = '0;
            state_next.value_number   = '0;
            state_next.value_entry    = 1'b0;
            code = CODE_QUIT;
        end
        else if (key == KEY_LOWER_R)
        begin
            state_next.command_number = '0;
            state_next.value_number   = '0;
            state_next.value_entry    = 1'b0;
            advance_handler = 1'b1;
        end
        else if (key == KEY_LOWER_C)
        begin
            state_next.value_entry = 1'b1;
        end
        else if (key == KEY_NL)
        begin
            code = {state.value_number[15:0], state.command_number[15:0]};
            state_next.command_number = '0;
            state_next.value_number   = '0;
            state_next.value_entry    = 1'b0;
        end
        else if (key == KEY_ESC)
        begin
            state_next.command_number = ESC_NUMBER;
        end
        else if (key == KEY_BRACKET)
        begin
            state_next.escape_second = BRACKET_NUM;
        end
        else if (key >= KEY_ARROW_A && key <= KEY_ARROW_D)
        begin
            if (state.command_number == ESC_NUMBER && state.escape_second == BRACKET_NUM)
            begin
                code = ARROW_BASE | {{(CodeWidth-KeyWidth){1'b0}}, key};
                state_next.command_number = '0;
                state_next.escape_second  = '0;
            end
        end
        else if (key >= KEY_DIGIT_0 && key <= KEY_DIGIT_9)
        begin
            if (state.value_entry)
                state_next.value_number = times_ten;
            else
                state_next.command_number = times_ten;
        end
        else if (key == KEY_PLUS || key == KEY_MINUS)
        begin
            state_next.escape_second = stepped;
            code = stepped;
        end
        else
        begin
        end
    end

endmodule

// ----- tb/key_command_decoder_top_test.sv -----
// Self-checking testbench for key_command_decoder_top: directed and random key items with
// random idling on both stream sides, results predicted and checked in a scoreboard class.
// Depends on kcd_pkg and the key_command_decoder_top RTL.
`timescale 1ns / 1ps

module key_command_decoder_top_test;

    import kcd_pkg::*;

    localparam int KEY_TARGET   = 1450;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_AFTER   = 500;
    localparam int HOLD_CYCLES  = 300;

    class key_code_board;
        logic [31:0] cmd_num;
        logic [31:0] val_num;
        logic [31:0] esc_byte;
        logic        val_mode;
        logic [31:0] code_q[$];
        logic        adv_q[$];
        int          errors;

        function new();
            cmd_num  = '0;
            val_num  = '0;
            esc_byte = '0;
            val_mode = 1'b0;
            errors   = 0;
        endfunction

        function logic [7:0] letter_low(logic [7:0] k);
            string       rows[3] = '{"wsdaetyui", "oplnmvxzgb", "fhjk"};
            logic [7:0]  bases[3] = '{8'h41, 8'h50, 8'h60};
            for (int r = 0; r < 3; r++)
                for (int i = 0; i < rows[r].len(); i++)
                    if (rows[r][i] == k)
                        return bases[r] + 8'(i);
            return 8'h00;
        endfunction

        function void clear_numbers();
            cmd_num  = '0;
            val_num  = '0;
            val_mode = 1'b0;
        endfunction

        function void note_key(logic [7:0] k);
            logic [31:0] code;
            logic        adv;
            logic [7:0]  low;
            logic [31:0] digit;
            code  = CODE_NONE;
            adv   = 1'b0;
            low   = letter_low(k);
            digit = 32'(k) - 32'(KEY_DIGIT_0);
            if (k == KEY_NONE) begin
            end else if (low != 8'h00) begin
                clear_numbers();
                code = CODE_BASE | 32'(low);
            end else if (k == KEY_LOWER_Q) begin
                clear_numbers();
                code = CODE_QUIT;
            end else if (k == KEY_LOWER_R) begin
                clear_numbers();
                adv = 1'b1;
            end else if (k == KEY_LOWER_C) begin
                val_mode = 1'b1;
            end else if (k == KEY_NL) begin
                code = {val_num[15:0], cmd_num[15:0]};
                clear_numbers();
            end else if (k == KEY_ESC) begin
                cmd_num = ESC_NUMBER;
            end else if (k == KEY_BRACKET) begin
                esc_byte = BRACKET_NUM;
            end else if (k >= KEY_ARROW_A && k <= KEY_ARROW_D) begin
                if (cmd_num == ESC_NUMBER && esc_byte == BRACKET_NUM) begin
                    code     = ARROW_BASE | 32'(k);
                    cmd_num  = '0;
                    esc_byte = '0;
                end
            end else if (k >= KEY_DIGIT_0 && k <= KEY_DIGIT_9) begin
                if (val_mode)
                    val_num = val_num * 32'd10 + digit;
                else
                    cmd_num = cmd_num * 32'd10 + digit;
            end else if (k == KEY_PLUS) begin
                esc_byte = esc_byte + 32'd1;
                code     = esc_byte;
            end else if (k == KEY_MINUS) begin
                esc_byte = esc_byte - 32'd1;
                code     = esc_byte;
            end
            code_q.push_back(code);
            adv_q.push_back(adv);
        endfunction

        function void check_result(logic [31:0] code, logic adv);
            logic [31:0] exp_code;
            logic        exp_adv;
            if (code_q.size() == 0) begin
                $error("unexpected item: code %h, advance_handler %b", code, adv);
                errors++;
                return;
            end
            exp_code = code_q.pop_front();
            exp_adv  = adv_q.pop_front();
            if (code !== exp_code) begin
                $error("code mismatch: expected %h, actual %h", exp_code, code);
                errors++;
            end
            if (adv !== exp_adv) begin
                $error("advance_handler mismatch: expected %b, actual %b", exp_adv, adv);
                errors++;
            end
        endfunction

        function int pending();
            return code_q.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;

    key_code_board board = new();
    int          cycles = 0;
    int          keys_sent = 0;
    int          live_keys = 0;
    bit          quiet_sender = 1'b0;

    key_command_decoder_top u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            board.check_result(m_tdata, m_tuser);
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [7:0] pick_letter();
        string s = "wsdaetyuioplnmvxzgbfhjkqrc";
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    task automatic send_key(input logic [7:0] k);
        int gap;
        gap = quiet_sender ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= k;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        board.note_key(k);
        keys_sent++;
        if (k != KEY_NONE)
            live_keys++;
    endtask

    task automatic send_digits(input int n);
        repeat (n) send_key(KEY_DIGIT_0 + 8'($urandom_range(0, 9)));
    endtask

    task automatic play_sequence();
        int kind;
        kind = $urandom_range(0, 99);
        if ($urandom_range(0, 19) == 0)
            quiet_sender = !quiet_sender;
        if (kind < 35) begin
            send_digits(($urandom_range(0, 9) == 0) ? $urandom_range(10, 14)
                                                    : $urandom_range(1, 5));
            if ($urandom_range(0, 1)) begin
                send_key(KEY_LOWER_C);
                send_digits(($urandom_range(0, 9) == 0) ? $urandom_range(10, 14)
                                                        : $urandom_range(0, 5));
            end
            case ($urandom_range(0, 9))
                0:       send_key(pick_letter());
                1:       send_key(KEY_ESC);
                default: send_key(KEY_NL);
            endcase
        end else if (kind < 55) begin
            send_key(KEY_ESC);
            if ($urandom_range(0, 4) == 0)
                send_key(8'($urandom_range(0, 255)));
            send_key(KEY_BRACKET);
            send_key(KEY_ARROW_A + 8'($urandom_range(0, 3)));
        end else if (kind < 65) begin
            repeat ($urandom_range(1, 4))
                send_key($urandom_range(0, 1) ? KEY_PLUS : KEY_MINUS);
        end else if (kind < 72) begin
            send_key(KEY_ARROW_A + 8'($urandom_range(0, 3)));
        end else if (kind < 85) begin
            send_key(pick_letter());
        end else if (kind < 88) begin
            send_key(KEY_NONE);
        end else begin
            send_key(8'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin
        int stall;
        bit held;
        stall = 0;
        held  = 1'b0;
        wait (rst_n);
        forever begin
            @(posedge clk);
            if (!held && keys_sent >= HOLD_AFTER) begin
                held  = 1'b1;
                stall = HOLD_CYCLES;
            end
            if (stall > 0) begin
                stall--;
                m_tready <= 1'b0;
            end else if (cycles[10:9] == 2'b00) begin
                m_tready <= 1'b1;
            end else begin
                stall = pick_gap();
                m_tready <= (stall == 0);
                if (stall > 0)
                    stall--;
            end
        end
    end

    initial
    begin
        logic [7:0] opening_keys[24] = '{
            KEY_NONE, 8'hff, 8'h80, KEY_DIGIT_9, KEY_DIGIT_9, KEY_LOWER_C,
            KEY_DIGIT_0 + 8'd7, KEY_NL, KEY_ESC, KEY_BRACKET, KEY_ARROW_A, KEY_ARROW_D,
            KEY_ESC, KEY_BRACKET, KEY_ARROW_D, KEY_MINUS, KEY_PLUS, "w",
            "k", KEY_LOWER_Q, KEY_LOWER_R, KEY_NL, KEY_DIGIT_0, 8'h7f
        };
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        foreach (opening_keys[i])
            send_key(opening_keys[i]);
        while (live_keys < KEY_TARGET)
            play_sequence();
        s_tvalid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ----- key_command_decoder_top.f -----
hdl/kcd_pkg.sv
hdl/kcd_decode.sv
hdl/key_command_decoder_top.sv
tb/key_command_decoder_top_test.sv
